FILE: src/kdr_pkg.sv
// Package: constants, types and register codes for the keypad debounce block.
package kdr_pkg;

  localparam int NumKeys  = 10;
  localparam int TimeBits = 32;
  localparam int CfgBits  = 16;
  localparam int CfgIdxBits = 3;
  localparam int ModeKey  = NumKeys - 1;

  typedef logic [NumKeys-1:0]  key_t;
  typedef logic [TimeBits-1:0] time_t;
  typedef logic [CfgBits-1:0]  cfg_t;
  typedef logic [3:0]          digit_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgDebounce   = 3'd0,
    CfgRptDelay   = 3'd1,
    CfgRptIntvl   = 3'd2,
    CfgLongPress  = 3'd3,
    CfgRepeatKeys = 3'd4
  } cfg_idx_e;

  localparam cfg_t   DebounceRst   = cfg_t'(20);
  localparam cfg_t   RptDelayRst   = cfg_t'(400);
  localparam cfg_t   RptIntvlRst   = cfg_t'(100);
  localparam cfg_t   LongPressRst  = cfg_t'(600);
  localparam key_t   RepeatKeysRst = key_t'(170);
  localparam digit_t DigitLast     = 4'd9;

endpackage

FILE: src/keypad_debounce_repeat_mode.sv
// Top level: keypad debounce with auto-repeat and long-press mode toggle.
// Result path: an accepted request passes the input register, then the result register.
// Throughput: one request per cycle unless stalled; all per-key compares run in one pass.
// Reset: asynchronous, clears key state, repeat times and mode; config returns to defaults.
// Backpressure on the result stalls the input stage; a request is taken while
// a result waits as long as the input stage is empty.
module keypad_debounce_repeat_mode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [kdr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [kdr_pkg::CfgBits-1:0]    cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [kdr_pkg::NumKeys-1:0]    raw_keys_i,
  input  logic [kdr_pkg::TimeBits-1:0]   now_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kdr_pkg::NumKeys-1:0]    key_events_o,
  output logic [kdr_pkg::NumKeys-1:0]    held_keys_o,
  output logic                      digit_mode_o,
  output logic                      digit_valid_o,
  output logic [3:0]                digit_value_o
);
  import kdr_pkg::*;

  cfg_t  debounce_q, rpt_delay_q, rpt_intvl_q, long_press_q;
  key_t  repeat_keys_q;

  logic  in_vld_q;
  key_t  raw_q;
  time_t now_q;

  key_t  stable_q, prev_q;
  time_t chg_time_q, mode_time_q;
  time_t nrt_q [NumKeys];
  logic  pend_q, long_q, dmode_q;

  logic   out_vld_q;
  key_t   events_q, held_q;
  logic   dmode_out_q, dvalid_q;
  digit_t dvalue_q;

  logic   adv, accept;
  logic   stab;
  time_t  chg_time_d;
  key_t   pressed, released, events_d;
  time_t  nrt_d [NumKeys];
  time_t  nrt_eff, now_dly, now_int;
  time_t  mode_time_d;
  logic   pend_eff, long_eff, long_hit, short_rel;
  logic   pend_d, long_d, dmode_d;
  logic   dvalid_d;
  digit_t dvalue_d, dcnt;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DebounceRst;
      rpt_delay_q   <= RptDelayRst;
      rpt_intvl_q   <= RptIntvlRst;
      long_press_q  <= LongPressRst;
      repeat_keys_q <= RepeatKeysRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:   debounce_q    <= cfg_wdata_i;
        CfgRptDelay:   rpt_delay_q   <= cfg_wdata_i;
        CfgRptIntvl:   rpt_intvl_q   <= cfg_wdata_i;
        CfgLongPress:  long_press_q  <= cfg_wdata_i;
        CfgRepeatKeys: repeat_keys_q <= cfg_wdata_i[NumKeys-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_q <= raw_keys_i;
      now_q <= now_ms_i;
    end
  end

  always_comb begin
    chg_time_d = (raw_q != prev_q) ? now_q : chg_time_q;
    stab       = (now_q - chg_time_d) >= time_t'(debounce_q);
    pressed    = raw_q & ~stable_q;
    released   = stable_q & ~raw_q;
    now_dly    = now_q + time_t'(rpt_delay_q);
    now_int    = now_q + time_t'(rpt_intvl_q);
    events_d   = '0;
    dvalid_d   = 1'b0;
    dvalue_d   = '0;
    dcnt       = 4'd1;
    nrt_eff    = '0;
    for (int i = 0; i < NumKeys; i++) begin
      nrt_eff  = pressed[i] ? now_dly : nrt_q[i];
      nrt_d[i] = nrt_eff;
      if (pressed[i] && (i != ModeKey)) begin
        if (dmode_q) begin
          dvalid_d = 1'b1;
          dvalue_d = dcnt;
        end else begin
          events_d[i] = 1'b1;
        end
      end
      if (!dmode_q && raw_q[i] && repeat_keys_q[i] && (now_q >= nrt_eff)) begin
        events_d[i] = 1'b1;
        nrt_d[i]    = now_int;
      end
      dcnt = (dcnt == DigitLast) ? 4'd0 : dcnt + 4'd1;
    end

    mode_time_d = pressed[ModeKey] ? now_q : mode_time_q;
    pend_eff    = pressed[ModeKey] || pend_q;
    long_eff    = pressed[ModeKey] ? 1'b0 : long_q;
    long_hit    = raw_q[ModeKey] && pend_eff && !long_eff &&
                  ((now_q - mode_time_d) > time_t'(long_press_q));
    dmode_d     = dmode_q ^ long_hit;
    pend_d      = pend_eff;
    long_d      = long_eff || long_hit;
    if (long_hit) begin
      events_d[ModeKey] = 1'b1;
    end
    short_rel = released[ModeKey] && pend_eff && !long_eff;
    if (short_rel) begin
      if (dmode_d) begin
        dvalid_d = 1'b1;
        dvalue_d = '0;
      end else begin
        events_d[ModeKey] = 1'b1;
      end
    end
    if (released[ModeKey]) begin
      pend_d = 1'b0;
      long_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= '0;
      prev_q      <= '0;
      chg_time_q  <= '0;
      mode_time_q <= '0;
      pend_q      <= 1'b0;
      long_q      <= 1'b0;
      dmode_q     <= 1'b0;
      for (int i = 0; i < NumKeys; i++) begin
        nrt_q[i] <= '0;
      end
    end else if (adv) begin
      prev_q     <= raw_q;
      chg_time_q <= chg_time_d;
      if (stab) begin
        stable_q    <= raw_q;
        mode_time_q <= mode_time_d;
        pend_q      <= pend_d;
        long_q      <= long_d;
        dmode_q     <= dmode_d;
        for (int i = 0; i < NumKeys; i++) begin
          nrt_q[i] <= nrt_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      events_q    <= stab ? events_d : '0;
      held_q      <= stab ? raw_q : stable_q;
      dmode_out_q <= stab ? dmode_d : dmode_q;
      dvalid_q    <= stab && dvalid_d;
      dvalue_q    <= stab ? dvalue_d : '0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign key_events_o  = events_q;
  assign held_keys_o   = held_q;
  assign digit_mode_o  = dmode_out_q;
  assign digit_valid_o = dvalid_q;
  assign digit_value_o = dvalue_q;

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !digit_valid_o |-> digit_value_o == '0)
    else $error("digit value set without a digit");

  a_digit_no_game: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && digit_valid_o |->
      (key_events_o & ~(key_t'(1) << ModeKey)) == '0)
    else $error("game events alongside a digit");

  a_held_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(stable_q) && $stable(dmode_q))
    else $error("key state moved without an advancing request");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q && !out_ready_i)
    else $error("input stalled with room downstream");

endmodule

FILE: tb/keypad_poll_checker.sv
// Checker: predicts every poll result of the keypad debounce block and compares outputs.
`timescale 1ns / 100ps
module keypad_poll_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [kdr_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  kdr_pkg::cfg_t                  cfg_wdata_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  kdr_pkg::key_t                  raw_keys_i,
  input  kdr_pkg::time_t                 now_ms_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  kdr_pkg::key_t                  key_events_i,
  input  kdr_pkg::key_t                  held_keys_i,
  input  logic                           digit_mode_i,
  input  logic                           digit_valid_i,
  input  kdr_pkg::digit_t                digit_value_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import kdr_pkg::*;

  typedef struct packed {
    key_t   events;
    key_t   held;
    logic   mode;
    logic   dvalid;
    digit_t dvalue;
  } poll_result_t;

  cfg_t  debounce_ms, rpt_delay_ms, rpt_intvl_ms, long_press_ms;
  key_t  rpt_mask;

  key_t  stable_keys, last_raw;
  time_t raw_change_ms, mode_press_ms;
  time_t next_rpt_ms [NumKeys];
  logic  mode_pending, long_seen, digit_mode;

  poll_result_t expected_polls_q[$];
  int fails;

  function automatic poll_result_t predict_poll(input key_t raw, input time_t now);
    poll_result_t res;
    key_t pressed, released;
    res = '0;
    if (raw != last_raw) begin
      last_raw = raw;
      raw_change_ms = now;
    end
    if (time_t'(now - raw_change_ms) >= time_t'(debounce_ms)) begin
      pressed = raw & ~stable_keys;
      released = stable_keys & ~raw;
      stable_keys = raw;
      for (int i = 0; i < NumKeys; i++) begin
        if (pressed[i]) begin
          if (i == ModeKey) mode_press_ms = now;
          next_rpt_ms[i] = now + time_t'(rpt_delay_ms);
          if (i == ModeKey) begin
            mode_pending = 1'b1;
            long_seen = 1'b0;
          end else if (digit_mode) begin
            res.dvalid = 1'b1;
            res.dvalue = digit_t'((i + 1) % 10);
          end else begin
            res.events[i] = 1'b1;
          end
        end
        if (!digit_mode && stable_keys[i] && rpt_mask[i] && now >= next_rpt_ms[i]) begin
          res.events[i] = 1'b1;
          next_rpt_ms[i] = now + time_t'(rpt_intvl_ms);
        end
        if (i == ModeKey) begin
          if (stable_keys[i] && mode_pending && !long_seen &&
              time_t'(now - mode_press_ms) > time_t'(long_press_ms)) begin
            digit_mode = ~digit_mode;
            long_seen = 1'b1;
            res.events[i] = 1'b1;
          end
          if (released[i]) begin
            if (mode_pending && !long_seen) begin
              if (digit_mode) begin
                res.dvalid = 1'b1;
                res.dvalue = '0;
              end else begin
                res.events[i] = 1'b1;
              end
            end
            mode_pending = 1'b0;
            long_seen = 1'b0;
          end
        end
      end
    end
    res.held = stable_keys;
    res.mode = digit_mode;
    return res;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    poll_result_t want;
    if (!rst_ni) begin
      debounce_ms   = DebounceRst;
      rpt_delay_ms  = RptDelayRst;
      rpt_intvl_ms  = RptIntvlRst;
      long_press_ms = LongPressRst;
      rpt_mask      = RepeatKeysRst;
      stable_keys   = '0;
      last_raw      = '0;
      raw_change_ms = '0;
      mode_press_ms = '0;
      foreach (next_rpt_ms[k]) next_rpt_ms[k] = '0;
      mode_pending  = 1'b0;
      long_seen     = 1'b0;
      digit_mode    = 1'b0;
      expected_polls_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgDebounce:   debounce_ms = cfg_wdata_i;
          CfgRptDelay:   rpt_delay_ms = cfg_wdata_i;
          CfgRptIntvl:   rpt_intvl_ms = cfg_wdata_i;
          CfgLongPress:  long_press_ms = cfg_wdata_i;
          CfgRepeatKeys: rpt_mask = cfg_wdata_i[NumKeys-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_polls_q.size() == 0) begin
          $error("result with no request pending: key_events %0d held_keys %0d",
                 key_events_i, held_keys_i);
          fails++;
        end else begin
          want = expected_polls_q.pop_front();
          check_field("key_events", want.events, key_events_i);
          check_field("held_keys", want.held, held_keys_i);
          check_field("digit_mode", want.mode, digit_mode_i);
          check_field("digit_valid", want.dvalid, digit_valid_i);
          check_field("digit_value", want.dvalue, digit_value_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_polls_q.push_back(predict_poll(raw_keys_i, now_ms_i));
      end
      fail_count_o <= fails;
      pending_o <= expected_polls_q.size();
    end
  end

endmodule

FILE: tb/tb_keypad_debounce_repeat_mode.sv
// Testbench top: drives keypad polls and register writes, then reports the verdict.
`timescale 1ns / 100ps
module tb_keypad_debounce_repeat_mode;
  import kdr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 110;
  localparam int NumPhases  = 8;
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 3'd7;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  cfg_t                  cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  key_t                  raw_keys_i = '0;
  time_t                 now_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  key_t                  key_events_o, held_keys_o;
  logic                  digit_mode_o, digit_valid_o;
  digit_t                digit_value_o;

  int    fail_count;
  int    pending_polls;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    cycle_count = 0;
  int    sent_polls = 0;
  int    step_max = 8;
  time_t clock_ms = '0;

  keypad_debounce_repeat_mode uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .raw_keys_i    (raw_keys_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_events_o  (key_events_o),
    .held_keys_o   (held_keys_o),
    .digit_mode_o  (digit_mode_o),
    .digit_valid_o (digit_valid_o),
    .digit_value_o (digit_value_o)
  );

  keypad_poll_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .raw_keys_i    (raw_keys_i),
    .now_ms_i      (now_ms_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_events_i  (key_events_o),
    .held_keys_i   (held_keys_o),
    .digit_mode_i  (digit_mode_o),
    .digit_valid_i (digit_valid_o),
    .digit_value_i (digit_value_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending_polls)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_poll(input key_t raw, input time_t stamp);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_keys_i <= raw;
    now_ms_i   <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_polls++;
  endtask

  task automatic settle(input key_t raw, input time_t stamp);
    send_poll(raw, stamp);
    send_poll(raw, stamp + time_t'(DebounceRst));
  endtask

  task automatic poll_after(input key_t raw, input int max_step);
    clock_ms = clock_ms + time_t'($urandom_range(0, max_step));
    send_poll(raw, clock_ms);
  endtask

  task automatic drain_polls();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_polls != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input cfg_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input cfg_t deb, input cfg_t dly, input cfg_t ivl,
                               input cfg_t lp, input cfg_t mask);
    int longest;
    write_reg(CfgDebounce, deb);
    write_reg(CfgRptDelay, dly);
    write_reg(CfgRptIntvl, ivl);
    write_reg(CfgLongPress, lp);
    write_reg(CfgRepeatKeys, mask);
    write_reg(CfgIdxUnused, cfg_t'($urandom));
    cfg_we_i <= 1'b0;
    longest = deb;
    if (dly > longest) longest = dly;
    if (ivl > longest) longest = ivl;
    if (lp > longest) longest = lp;
    step_max = longest / 3 + 4;
  endtask

  task automatic run_episode();
    key_t target;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      target = key_t'(1) << $urandom_range(0, NumKeys - 1);
    end else if (pick < 55) begin
      target = key_t'(1) << ModeKey;
    end else if (pick < 75) begin
      target = (key_t'(1) << $urandom_range(0, NumKeys - 1)) |
               (key_t'(1) << $urandom_range(0, NumKeys - 1));
    end else if (pick < 85) begin
      target = '0;
    end else begin
      target = key_t'($urandom);
    end
    if ($urandom_range(0, 99) < 5) begin
      clock_ms = clock_ms + time_t'($urandom);
      send_poll(key_t'($urandom), clock_ms);
    end
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) poll_after(target ^ key_t'($urandom), 3);
    end
    repeat ($urandom_range(1, 10)) poll_after(target, step_max);
  endtask

  initial begin
    int phase_end;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    settle(key_t'('1), 32'd1000);
    send_poll(key_t'('1), 32'd1420);
    send_poll(key_t'('1), 32'd1520);
    send_poll(key_t'('1), 32'd1621);
    settle(key_t'(0), 32'd1700);
    settle(key_t'(10'h001), 32'd1800);
    settle(key_t'(10'h104), 32'd1900);
    settle(key_t'(1) << ModeKey, 32'd2000);
    settle(key_t'(0), 32'd2100);
    settle(key_t'(1) << ModeKey, 32'd2200);
    send_poll(key_t'(1) << ModeKey, 32'd2801);
    settle(key_t'(0), 32'd2900);
    settle(key_t'(1) << ModeKey, 32'd3000);
    settle(key_t'(0), 32'd3100);
    settle(key_t'(10'h002), 32'hFFFF_FF00);
    drain_polls();

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: apply_setting(cfg_t'(20), cfg_t'(400), cfg_t'(100), cfg_t'(600), cfg_t'(170));
        1: apply_setting('0, '0, '0, '0, '0);
        2: apply_setting('1, '1, '1, '1, '1);
        4: apply_setting(cfg_t'(5), cfg_t'(30), cfg_t'(10), cfg_t'(50), cfg_t'(10'h3FF));
        6: apply_setting('0, cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom),
                         cfg_t'($urandom));
        default: apply_setting(cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom),
                               cfg_t'($urandom), cfg_t'($urandom));
      endcase
      case (phase % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 78;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 78;
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      clock_ms = time_t'($urandom);
      phase_end = sent_polls + PhaseItems;
      while (sent_polls < phase_end - PhaseItems / 2) run_episode();
      drain_polls();
      while (sent_polls < phase_end) run_episode();
      drain_polls();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_polls == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: keypad_debounce_repeat_mode.f
src/kdr_pkg.sv
src/keypad_debounce_repeat_mode.sv
tb/keypad_poll_checker.sv
tb/tb_keypad_debounce_repeat_mode.sv
